FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock with a synchronous active-low reset.
`define PID_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same check on the usual clock and reset port names.
`define PID_ASSERT(label, prop, msg) `PID_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

FILE: hdl/pid_pkg.sv
// Package with types, constants and codes for the PID controller step.
package pid_pkg;

    // Field widths.
    localparam int DATA_W   = 32;
    localparam int DT_W     = 24;
    localparam int ACC_W    = 48;

    // Shared serial unit widths and step counts.
    localparam int SU_W      = 80;
    localparam int SU_B_W    = 48;
    localparam int SU_CNT_W  = 6;
    localparam int MUL_DT_STEPS   = DT_W;
    localparam int MUL_GAIN_STEPS = DATA_W;
    localparam int DIV_STEPS      = SU_B_W;

    // Width of the running sum of the three gain terms.
    localparam int TERM_W = SU_W - 16;
    localparam int SUM_W  = TERM_W + 2;

    // Saturation limits.
    localparam logic [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [ACC_W-1:0]  MAX48 = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]  MIN48 = {1'b1, {(ACC_W-1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd3;

    // Operation of the shared serial unit.
    typedef enum logic {
        SU_MUL,
        SU_DIV
    } t_su_op;

    // Command from the sequencer to the shared serial unit.
    typedef struct packed {
        logic                start;
        t_su_op              op;
        logic                b_signed;
        logic [SU_CNT_W-1:0] last_idx;
    } t_su_cmd;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ERROR,
        S_INT_MUL,
        S_DIV,
        S_P_MUL,
        S_I_MUL,
        S_D_MUL,
        S_SUM
    } t_state;

endpackage

FILE: hdl/pid_controller_step.sv
// Top level of the fixed-point PID controller step with its sequencer.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+------------------------------------
//  input     | i_in_valid / o_in_ready       | i_measured, i_step_time
//  result    | o_out_valid / i_out_ready     | o_drive, o_clipped, o_zero_step
//  config    | i_cfg_we (no wait)            | i_cfg_index, i_cfg_data
//
// Each beat runs from acceptance to its result through the bit-serial shared unit:
// 24 multiply steps for the integral, 48 restoring-divide steps for the derivative
// and 32 steps for each gain product; the divide is skipped when step_time is zero.
// o_in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next beat is taken while the last result is stalled.
// Reset is synchronous and clears gains, setpoint, integral and last error.
module pid_controller_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [pid_pkg::DATA_W-1:0] i_measured,
    input  logic        [pid_pkg::DT_W-1:0]   i_step_time,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [pid_pkg::DATA_W-1:0] o_drive,
    output logic                              o_clipped,
    output logic                              o_zero_step,
    input  logic                              i_cfg_we,
    input  logic [pid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pid_pkg::DATA_W-1:0]        i_cfg_data
);

    localparam int DW = pid_pkg::DATA_W;
    localparam int AW = pid_pkg::ACC_W;
    localparam int UW = pid_pkg::SU_W;
    localparam int BW = pid_pkg::SU_B_W;
    localparam int TW = pid_pkg::TERM_W;
    localparam int SW = pid_pkg::SUM_W;

    // Configuration registers.
    logic [DW-1:0] r_gain_p, r_gain_i, r_gain_d, r_target;

    // Sequencer and item state.
    pid_pkg::t_state     r_state, n_state;
    logic [DW-1:0]       r_meas, n_meas;
    logic [pid_pkg::DT_W-1:0] r_dt, n_dt;
    logic [DW-1:0]       r_err, n_err;
    logic [DW-1:0]       r_last, n_last;
    logic [AW-1:0]       r_accum, n_accum;
    logic [AW-1:0]       r_deriv, n_deriv;
    logic [SW-1:0]       r_sum, n_sum;
    logic                r_clip, n_clip;
    logic                r_zstep, n_zstep;
    logic                r_out_valid, n_out_valid;
    logic [DW-1:0]       r_drive, n_drive;
    logic                r_out_clip, n_out_clip;
    logic                r_out_zstep, n_out_zstep;

    // Shared unit connections.
    pid_pkg::t_su_cmd    su_cmd;
    logic [UW-1:0]       su_a;
    logic [BW-1:0]       su_b;
    logic                su_done;
    logic [UW-1:0]       su_result;

    // Arithmetic around the shared unit.
    logic [DW:0]         err_wide;
    logic                err_ovf;
    logic [DW-1:0]       err_sat;
    logic [39:0]         int_inc;
    logic [AW:0]         acc_wide;
    logic                acc_ovf;
    logic [AW-1:0]       acc_sat;
    logic [DW:0]         diff_wide;
    logic [DW:0]         diff_mag;
    logic [AW:0]         der_wide;
    logic                der_ovf;
    logic [AW-1:0]       der_sat;
    logic [SW-1:0]       term;
    logic [SW-1:0]       sum_next;
    logic                drv_ovf;
    logic [DW-1:0]       drv_sat;

    pid_serial_unit u_su (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (su_cmd),
        .i_a      (su_a),
        .i_b      (su_b),
        .i_d      (r_dt),
        .o_done   (su_done),
        .o_result (su_result)
    );

    // Error, integral, derivative and output saturation.
    always_comb begin
        err_wide = {r_target[DW-1], r_target} - {r_meas[DW-1], r_meas};
        err_ovf  = err_wide[DW] ^ err_wide[DW-1];
        err_sat  = err_ovf ? (err_wide[DW] ? pid_pkg::MIN32 : pid_pkg::MAX32)
                           : err_wide[DW-1:0];

        int_inc  = su_result[55:16];
        acc_wide = {r_accum[AW-1], r_accum} + {{(AW+1-40){int_inc[39]}}, int_inc};
        acc_ovf  = acc_wide[AW] ^ acc_wide[AW-1];
        acc_sat  = acc_ovf ? (acc_wide[AW] ? pid_pkg::MIN48 : pid_pkg::MAX48)
                           : acc_wide[AW-1:0];

        diff_wide = {r_err[DW-1], r_err} - {r_last[DW-1], r_last};
        diff_mag  = diff_wide[DW] ? (~diff_wide + 1'b1) : diff_wide;
        der_wide  = diff_wide[DW] ? (~{1'b0, su_result[AW-1:0]} + 1'b1)
                                  : {1'b0, su_result[AW-1:0]};
        der_ovf   = der_wide[AW] ^ der_wide[AW-1];
        der_sat   = der_ovf ? (der_wide[AW] ? pid_pkg::MIN48 : pid_pkg::MAX48)
                            : der_wide[AW-1:0];

        term     = {{(SW-TW){su_result[UW-1]}}, su_result[UW-1:16]};
        sum_next = r_sum + term;

        drv_ovf  = !((r_sum[SW-1:DW-1] == '0) || (r_sum[SW-1:DW-1] == '1));
        drv_sat  = drv_ovf ? (r_sum[SW-1] ? pid_pkg::MIN32 : pid_pkg::MAX32)
                           : r_sum[DW-1:0];
    end

    // Sequencer: next state, unit commands and register updates.
    always_comb begin
        n_state     = r_state;
        n_meas      = r_meas;
        n_dt        = r_dt;
        n_err       = r_err;
        n_last      = r_last;
        n_accum     = r_accum;
        n_deriv     = r_deriv;
        n_sum       = r_sum;
        n_clip      = r_clip;
        n_zstep     = r_zstep;
        n_drive     = r_drive;
        n_out_clip  = r_out_clip;
        n_out_zstep = r_out_zstep;
        n_out_valid = r_out_valid && !i_out_ready;
        su_cmd.start    = 1'b0;
        su_cmd.op       = pid_pkg::SU_MUL;
        su_cmd.b_signed = 1'b1;
        su_cmd.last_idx = pid_pkg::SU_CNT_W'(pid_pkg::MUL_GAIN_STEPS - 1);
        su_a            = '0;
        su_b            = '0;

        case (r_state)
            pid_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_meas  = i_measured;
                    n_dt    = i_step_time;
                    n_state = pid_pkg::S_ERROR;
                end
            end
            pid_pkg::S_ERROR: begin
                // Saturated error, then error times step_time.
                n_err   = err_sat;
                n_clip  = err_ovf;
                n_zstep = (r_dt == '0);
                su_cmd.start    = 1'b1;
                su_cmd.b_signed = 1'b0;
                su_cmd.last_idx = pid_pkg::SU_CNT_W'(pid_pkg::MUL_DT_STEPS - 1);
                su_a    = {{(UW-DW){err_sat[DW-1]}}, err_sat};
                su_b    = {{(BW-pid_pkg::DT_W){1'b0}}, r_dt};
                n_state = pid_pkg::S_INT_MUL;
            end
            pid_pkg::S_INT_MUL: begin
                if (su_done) begin
                    n_accum = acc_sat;
                    n_clip  = r_clip | acc_ovf;
                    su_cmd.start = 1'b1;
                    if (r_zstep) begin
                        // No derivative for a zero step time.
                        n_deriv = '0;
                        su_a    = {{(UW-DW){r_err[DW-1]}}, r_err};
                        su_b    = {{(BW-DW){r_gain_p[DW-1]}}, r_gain_p};
                        n_state = pid_pkg::S_P_MUL;
                    end else begin
                        su_cmd.op       = pid_pkg::SU_DIV;
                        su_cmd.b_signed = 1'b0;
                        su_cmd.last_idx = pid_pkg::SU_CNT_W'(pid_pkg::DIV_STEPS - 1);
                        su_b    = {diff_mag[DW-1:0], 16'b0};
                        n_state = pid_pkg::S_DIV;
                    end
                end
            end
            pid_pkg::S_DIV: begin
                if (su_done) begin
                    n_deriv = der_sat;
                    n_clip  = r_clip | der_ovf;
                    su_cmd.start = 1'b1;
                    su_a    = {{(UW-DW){r_err[DW-1]}}, r_err};
                    su_b    = {{(BW-DW){r_gain_p[DW-1]}}, r_gain_p};
                    n_state = pid_pkg::S_P_MUL;
                end
            end
            pid_pkg::S_P_MUL: begin
                if (su_done) begin
                    n_sum   = term;
                    su_cmd.start = 1'b1;
                    su_a    = {{(UW-AW){r_accum[AW-1]}}, r_accum};
                    su_b    = {{(BW-DW){r_gain_i[DW-1]}}, r_gain_i};
                    n_state = pid_pkg::S_I_MUL;
                end
            end
            pid_pkg::S_I_MUL: begin
                if (su_done) begin
                    n_sum   = sum_next;
                    su_cmd.start = 1'b1;
                    su_a    = {{(UW-AW){r_deriv[AW-1]}}, r_deriv};
                    su_b    = {{(BW-DW){r_gain_d[DW-1]}}, r_gain_d};
                    n_state = pid_pkg::S_D_MUL;
                end
            end
            pid_pkg::S_D_MUL: begin
                if (su_done) begin
                    n_sum   = sum_next;
                    n_state = pid_pkg::S_SUM;
                end
            end
            pid_pkg::S_SUM: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_drive     = drv_sat;
                    n_out_clip  = r_clip | drv_ovf;
                    n_out_zstep = r_zstep;
                    n_out_valid = 1'b1;
                    n_last      = r_err;
                    n_state     = pid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pid_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pid_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_accum     <= '0;
            r_last      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_accum     <= n_accum;
            r_last      <= n_last;
        end
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        r_meas      <= n_meas;
        r_dt        <= n_dt;
        r_err       <= n_err;
        r_deriv     <= n_deriv;
        r_sum       <= n_sum;
        r_clip      <= n_clip;
        r_zstep     <= n_zstep;
        r_drive     <= n_drive;
        r_out_clip  <= n_out_clip;
        r_out_zstep <= n_out_zstep;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_target <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pid_pkg::CFG_GAIN_P: r_gain_p <= i_cfg_data;
                pid_pkg::CFG_GAIN_I: r_gain_i <= i_cfg_data;
                pid_pkg::CFG_GAIN_D: r_gain_d <= i_cfg_data;
                pid_pkg::CFG_TARGET: r_target <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == pid_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;
    assign o_clipped   = r_out_clip;
    assign o_zero_step = r_out_zstep;

endmodule

FILE: hdl/pid_serial_unit.sv
// Bit-serial shared unit: shift-add multiply and restoring divide on one adder.
module pid_serial_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pid_pkg::t_su_cmd             i_cmd,
    input  logic [pid_pkg::SU_W-1:0]     i_a,
    input  logic [pid_pkg::SU_B_W-1:0]   i_b,
    input  logic [pid_pkg::DT_W-1:0]     i_d,
    output logic                         o_done,
    output logic [pid_pkg::SU_W-1:0]     o_result
);

    logic                           r_busy;
    logic                           r_done;
    pid_pkg::t_su_op                r_op;
    logic                           r_neg;
    logic [pid_pkg::SU_CNT_W-1:0]   r_cnt;
    logic [pid_pkg::SU_W-1:0]       r_acc;
    logic [pid_pkg::SU_W-1:0]       r_a;
    logic [pid_pkg::SU_B_W-1:0]     r_b;
    logic [pid_pkg::DT_W-1:0]       r_d;
    logic [pid_pkg::DT_W-1:0]       r_rem;

    logic                           last_step;
    logic [pid_pkg::DT_W:0]         rem_sh;
    logic [pid_pkg::SU_W-1:0]       add_x;
    logic [pid_pkg::SU_W-1:0]       add_y;
    logic                           add_c;
    logic [pid_pkg::SU_W-1:0]       add_s;
    logic                           q_bit;

    // Operand selection for the one shared adder.
    always_comb begin
        last_step = (r_cnt == '0);
        rem_sh    = {r_rem, r_b[pid_pkg::SU_B_W-1]};
        if (r_op == pid_pkg::SU_MUL) begin
            add_x = r_acc;
            if (r_b[0]) begin
                // The sign bit of a signed multiplier carries negative weight.
                add_y = (r_neg && last_step) ? ~r_a : r_a;
                add_c = r_neg && last_step;
            end else begin
                add_y = '0;
                add_c = 1'b0;
            end
        end else begin
            // Trial subtract of the divisor from the shifted remainder.
            add_x = {{(pid_pkg::SU_W-pid_pkg::DT_W-1){1'b0}}, rem_sh};
            add_y = ~{{(pid_pkg::SU_W-pid_pkg::DT_W){1'b0}}, r_d};
            add_c = 1'b1;
        end
        add_s = add_x + add_y + {{(pid_pkg::SU_W-1){1'b0}}, add_c};
        q_bit = ~add_s[pid_pkg::SU_W-1];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_cmd.start && r_busy && last_step;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath registers: load on start, one step per busy cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_neg <= i_cmd.b_signed;
            r_cnt <= i_cmd.last_idx;
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_d   <= i_d;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_op == pid_pkg::SU_MUL) begin
                r_acc <= add_s;
                r_a   <= {r_a[pid_pkg::SU_W-2:0], 1'b0};
                r_b   <= {1'b0, r_b[pid_pkg::SU_B_W-1:1]};
            end else begin
                r_acc <= {r_acc[pid_pkg::SU_W-2:0], q_bit};
                r_b   <= {r_b[pid_pkg::SU_B_W-2:0], 1'b0};
                r_rem <= q_bit ? add_s[pid_pkg::DT_W-1:0] : rem_sh[pid_pkg::DT_W-1:0];
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

FILE: hdl/pid_chk.sv
// Port-level checker for the PID controller step, bound to the top level.
`include "assert_macros.svh"

module pid_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [pid_pkg::DATA_W-1:0] o_drive,
    input logic                              o_clipped,
    input logic                              o_zero_step
);

    // After an accepted beat the block stays busy and o_in_ready stays low.
    property p_busy_after_accept;
        (i_in_valid && o_in_ready) |-> ##1 (!o_in_ready) ##1 (!o_in_ready);
    endproperty

    // The block only leaves idle by taking a beat.
    property p_ready_falls_on_accept;
        $fell(o_in_ready) |-> $past(i_in_valid);
    endproperty

    // A new result shows up exactly when the sequencer returns to idle.
    property p_result_with_idle;
        $rose(o_out_valid) |-> $rose(o_in_ready);
    endproperty

    // A stalled result holds its payload.
    property p_out_hold;
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_drive)
            && $stable(o_clipped) && $stable(o_zero_step));
    endproperty

    `PID_ASSERT(a_busy_after_accept, p_busy_after_accept, "ready too soon after a beat")
    `PID_ASSERT(a_ready_falls_on_accept, p_ready_falls_on_accept, "ready dropped without a beat")
    `PID_ASSERT(a_result_with_idle, p_result_with_idle, "result appeared while busy")
    `PID_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

endmodule

bind pid_controller_step pid_chk u_pid_chk (.*);

FILE: verif/pid_controller_step_tb.sv
// Self-checking testbench for the fixed-point PID controller step.
`timescale 1ns / 1ps

module pid_controller_step_tb;

    // Run control.
    localparam int DRAIN_PAD    = 200;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_LEN     = 1500;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PHASES       = 10;
    localparam int WINDUP_PHASE = 1;
    localparam int WINDUP_BEATS = 340;
    localparam int PHASE_BEATS  = 50;
    localparam int DIR_ROWS     = 25;

    // Saturation bounds in the predictor's integer domain.
    localparam longint SAT32_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT32_LO = -SAT32_HI - 1;
    localparam longint SAT48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT48_LO = -SAT48_HI - 1;

    localparam logic [pid_pkg::DT_W-1:0] DT_ONE = 24'h01_0000;
    localparam logic [pid_pkg::DT_W-1:0] DT_MAX = 24'hFF_FFFF;

    // Short names for the stimulus table.
    localparam logic [pid_pkg::CFG_IDX_W-1:0] IDX_P = pid_pkg::CFG_GAIN_P;
    localparam logic [pid_pkg::CFG_IDX_W-1:0] IDX_I = pid_pkg::CFG_GAIN_I;
    localparam logic [pid_pkg::CFG_IDX_W-1:0] IDX_D = pid_pkg::CFG_GAIN_D;
    localparam logic [pid_pkg::CFG_IDX_W-1:0] IDX_T = pid_pkg::CFG_TARGET;
    localparam logic [pid_pkg::DATA_W-1:0]    Q_MAX = pid_pkg::MAX32;
    localparam logic [pid_pkg::DATA_W-1:0]    Q_MIN = pid_pkg::MIN32;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [pid_pkg::DATA_W-1:0] drive;
        logic                       clipped;
        logic                       zero_step;
    } t_result;

    typedef enum logic {
        ROW_WRITE,
        ROW_BEAT
    } t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [pid_pkg::CFG_IDX_W-1:0] index;
        logic [pid_pkg::DATA_W-1:0]    value;
        logic [pid_pkg::DT_W-1:0]      dt;
        logic                          typed;
        t_result                       want;
    } t_row;

    // Block inputs, all known from time zero.
    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic signed [pid_pkg::DATA_W-1:0] i_measured  = '0;
    logic        [pid_pkg::DT_W-1:0]   i_step_time = '0;
    logic                              i_out_ready = 1'b0;
    logic                              i_cfg_we    = 1'b0;
    logic [pid_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [pid_pkg::DATA_W-1:0]        i_cfg_data  = '0;

    logic                              o_in_ready;
    logic                              o_out_valid;
    logic signed [pid_pkg::DATA_W-1:0] o_drive;
    logic                              o_clipped;
    logic                              o_zero_step;

    // Controller state mirrored by the predictor.
    longint kp       = 0;
    longint ki       = 0;
    longint kd       = 0;
    longint setpoint = 0;
    longint integ    = 0;
    longint prev_err = 0;

    t_result drive_due [$];
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      hold_left      = 0;
    int      rx_stall       = 0;
    logic    no_gaps        = 1'b0;

    // Directed rows: extremes, zero step time and saturation cases.
    t_row directed_rows [DIR_ROWS] = '{
        // Straight after reset all gains are zero and the step time is zero.
        '{ROW_BEAT,  IDX_P, 32'h0000_0000, 24'h00_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
        // The error overflows 32 bits and is clipped; the output stays zero.
        '{ROW_BEAT,  IDX_P, Q_MIN,         DT_ONE,      1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{ROW_BEAT,  IDX_P, Q_MAX,         DT_MAX,      1'b0, '0},
        '{ROW_WRITE, IDX_P, 32'h0001_0000, 24'h00_0000, 1'b0, '0},
        // Unit proportional gain passes the error straight through.
        '{ROW_BEAT,  IDX_P, 32'h0001_8000, 24'h00_0000, 1'b1, '{32'hFFFE_8000, 1'b0, 1'b1}},
        '{ROW_WRITE, IDX_P, Q_MAX,         24'h00_0000, 1'b0, '0},
        '{ROW_WRITE, IDX_I, Q_MIN,         24'h00_0000, 1'b0, '0},
        '{ROW_WRITE, IDX_D, Q_MAX,         24'h00_0000, 1'b0, '0},
        '{ROW_WRITE, IDX_T, Q_MAX,         24'h00_0000, 1'b0, '0},
        '{ROW_BEAT,  IDX_P, Q_MIN,         24'h00_0001, 1'b0, '0},
        '{ROW_BEAT,  IDX_P, Q_MAX,         24'h00_0000, 1'b0, '0},
        '{ROW_BEAT,  IDX_P, 32'h0000_0000, DT_ONE,      1'b0, '0},
        '{ROW_WRITE, IDX_T, Q_MIN,         24'h00_0000, 1'b0, '0},
        '{ROW_WRITE, IDX_P, Q_MIN,         24'h00_0000, 1'b0, '0},
        '{ROW_WRITE, IDX_D, Q_MIN,         24'h00_0000, 1'b0, '0},
        '{ROW_BEAT,  IDX_P, Q_MAX,         DT_MAX,      1'b0, '0},
        '{ROW_BEAT,  IDX_P, Q_MIN,         24'h00_0001, 1'b0, '0},
        // The derivative lands exactly on the most negative 48-bit value.
        '{ROW_BEAT,  IDX_P, 32'h0000_0000, 24'h00_0001, 1'b0, '0},
        '{ROW_WRITE, IDX_I, 32'h0000_0000, 24'h00_0000, 1'b0, '0},
        '{ROW_WRITE, IDX_D, 32'h0000_0000, 24'h00_0000, 1'b0, '0},
        '{ROW_WRITE, IDX_T, 32'h0000_0000, 24'h00_0000, 1'b0, '0},
        '{ROW_WRITE, IDX_P, 32'h0002_0000, 24'h00_0000, 1'b0, '0},
        '{ROW_BEAT,  IDX_P, 32'h0001_0000, 24'h00_0000, 1'b1, '{32'hFFFE_0000, 1'b0, 1'b1}},
        '{ROW_BEAT,  IDX_P, 32'h0000_0001, DT_MAX,      1'b0, '0},
        '{ROW_BEAT,  IDX_P, 32'h7FFF_0000, 24'h00_8000, 1'b0, '0}
    };

    pid_controller_step u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_measured  (i_measured),
        .i_step_time (i_step_time),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_drive     (o_drive),
        .o_clipped   (o_clipped),
        .o_zero_step (o_zero_step),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Clamp a value to a range and note whether it was clipped.
    function automatic longint saturate(input longint v, input longint lo, input longint hi,
                                        inout logic hit);
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Exact floor of gain times value over 2^16.
    function automatic t_wide q16_product(input longint g, input longint v);
        t_wide wg;
        t_wide wv;
        wg = g;
        wv = v;
        return (wg * wv) >>> 16;
    endfunction

    // One controller step: error, integral, derivative and the saturated weighted sum.
    function automatic t_result compute_drive(input logic [pid_pkg::DATA_W-1:0] meas_bits,
                                              input logic [pid_pkg::DT_W-1:0]   dt_bits);
        t_result                           res;
        logic                              clip;
        logic signed [pid_pkg::DATA_W-1:0] meas_s;
        longint                            meas_v;
        longint                            dt_v;
        longint                            err_v;
        longint                            deriv_v;
        t_wide                             total;
        res    = '0;
        clip   = 1'b0;
        meas_s = meas_bits;
        meas_v = meas_s;
        dt_v   = {40'b0, dt_bits};

        err_v = saturate(setpoint - meas_v, SAT32_LO, SAT32_HI, clip);
        integ = saturate(integ + ((err_v * dt_v) >>> 16), SAT48_LO, SAT48_HI, clip);

        // A zero step time forces the derivative to zero.
        if (dt_v == 0) begin
            res.zero_step = 1'b1;
            deriv_v = 0;
        end else begin
            // Signed division truncates toward zero, as the block does.
            deriv_v = saturate(((err_v - prev_err) * 65536) / dt_v, SAT48_LO, SAT48_HI, clip);
        end

        total = q16_product(kp, err_v) + q16_product(ki, integ) + q16_product(kd, deriv_v);
        if (total > SAT32_HI) begin
            clip = 1'b1;
            res.drive = Q_MAX;
        end else if (total < SAT32_LO) begin
            clip = 1'b1;
            res.drive = Q_MIN;
        end else begin
            res.drive = total[pid_pkg::DATA_W-1:0];
        end

        prev_err    = err_v;
        res.clipped = clip;
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 88) return $urandom_range(1, 4);
        else if (r < 97) return $urandom_range(5, 40);
        else return $urandom_range(100, 300);
    endfunction

    // Gain or setpoint: mostly moderate, with zero, both extremes and full range.
    function automatic logic [pid_pkg::DATA_W-1:0] pick_gain();
        int          r;
        logic [31:0] raw;
        r   = $urandom_range(0, 99);
        raw = $urandom;
        if (r < 50) return {{14{raw[17]}}, raw[17:0]};
        else if (r < 60) return '0;
        else if (r < 70) return Q_MAX;
        else if (r < 80) return Q_MIN;
        else return raw;
    endfunction

    // Measured value: mostly near the setpoint, sometimes anywhere or at the ends.
    function automatic logic [pid_pkg::DATA_W-1:0] pick_measured();
        int          r;
        logic [31:0] near;
        r    = $urandom_range(0, 99);
        near = setpoint[31:0];
        if (r < 40) return near + $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        else if (r < 65) return near + $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
        else if (r < 90) return $urandom;
        else if (r < 95) return Q_MAX;
        else return Q_MIN;
    endfunction

    // Step time: zero, the smallest, the largest, mostly a few seconds or less.
    function automatic logic [pid_pkg::DT_W-1:0] pick_step_time();
        int          r;
        logic [31:0] raw;
        r   = $urandom_range(0, 99);
        raw = $urandom;
        if (r < 10) return '0;
        else if (r < 18) return 24'h00_0001;
        else if (r < 25) return DT_MAX;
        else if (r < 65) begin
            raw = $urandom_range(1, 32'h0002_0000);
            return raw[pid_pkg::DT_W-1:0];
        end
        else return raw[pid_pkg::DT_W-1:0];
    endfunction

    // Register write; only called while the block is idle.
    task automatic write_reg(input logic [pid_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pid_pkg::DATA_W-1:0] data);
        logic signed [pid_pkg::DATA_W-1:0] sdata;
        sdata = data;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            pid_pkg::CFG_GAIN_P: kp = sdata;
            pid_pkg::CFG_GAIN_I: ki = sdata;
            pid_pkg::CFG_GAIN_D: kd = sdata;
            pid_pkg::CFG_TARGET: setpoint = sdata;
            default: ;
        endcase
    endtask

    // Offer one input beat and queue its expected result once accepted.
    task automatic send_beat(input logic [pid_pkg::DATA_W-1:0] meas,
                             input logic [pid_pkg::DT_W-1:0] dt,
                             input logic typed, input t_result want);
        int      gap;
        t_result model;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_measured  <= meas;
        i_step_time <= dt;
        do @(posedge i_clk); while (!o_in_ready);
        model = compute_drive(meas, dt);
        drive_due.push_back(typed ? want : model);
    endtask

    // Stop sending and wait until every result is out and the block is quiet.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (drive_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Result side: check each beat, stall at random, hold off once for a long stretch.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (drive_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with none expected, drive %h", $time, o_drive);
            end else begin
                want = drive_due.pop_front();
                if (o_drive !== want.drive) begin
                    mismatch_count++;
                    $display("%0t: drive expected %h actual %h", $time, want.drive, o_drive);
                end
                if (o_clipped !== want.clipped) begin
                    mismatch_count++;
                    $display("%0t: clipped expected %b actual %b",
                             $time, want.clipped, o_clipped);
                end
                if (o_zero_step !== want.zero_step) begin
                    mismatch_count++;
                    $display("%0t: zero_step expected %b actual %b",
                             $time, want.zero_step, o_zero_step);
                end
            end
            if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (rx_stall > 0) begin
            i_out_ready <= 1'b0;
            rx_stall--;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) rx_stall = pick_gap();
        end
    end

    // Watchdog.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus: reset, directed rows, then random phases with fresh settings.
    initial begin
        t_row                       row;
        logic                       prev_beat;
        logic [pid_pkg::DATA_W-1:0] meas;
        logic [pid_pkg::DT_W-1:0]   dt;
        logic [31:0]                raw;
        int                         phase;
        int                         n;
        int                         count;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; registers change only once earlier beats are done.
        prev_beat = 1'b0;
        for (n = 0; n < DIR_ROWS; n++) begin
            row = directed_rows[n];
            if (row.kind == ROW_WRITE) begin
                if (prev_beat) wait_idle();
                write_reg(row.index, row.value);
                prev_beat = 1'b0;
            end else begin
                send_beat(row.value, row.dt, row.typed, row.want);
                prev_beat = 1'b1;
            end
        end

        // Random phases. One phase winds the integral up into saturation.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            no_gaps = (phase % 4 == 2);
            write_reg(pid_pkg::CFG_GAIN_P, pick_gain());
            write_reg(pid_pkg::CFG_GAIN_I, pick_gain());
            write_reg(pid_pkg::CFG_GAIN_D, pick_gain());
            if (phase == WINDUP_PHASE) begin
                write_reg(pid_pkg::CFG_TARGET, Q_MAX);
                count = WINDUP_BEATS;
            end else begin
                write_reg(pid_pkg::CFG_TARGET, pick_gain());
                count = PHASE_BEATS;
            end
            for (n = 0; n < count; n++) begin
                if (phase == WINDUP_PHASE && $urandom_range(0, 19) != 0) begin
                    // Error pinned at its maximum with long step times.
                    raw  = $urandom;
                    meas = Q_MIN + {12'b0, raw[19:0]};
                    dt   = {4'hF, raw[31:12]};
                end else begin
                    meas = pick_measured();
                    dt   = pick_step_time();
                end
                send_beat(meas, dt, 1'b0, '0);
            end
        end
        no_gaps = 1'b0;

        wait_idle();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pid_pkg.sv
hdl/pid_serial_unit.sv
hdl/pid_controller_step.sv
hdl/pid_chk.sv
verif/pid_controller_step_tb.sv
